### hdl/histogram_rebin_mean_error_defines.svh
// assertion macros for the histogram rebinning block
`ifndef HISTOGRAM_REBIN_MEAN_ERROR_DEFINES_SVH
`define HISTOGRAM_REBIN_MEAN_ERROR_DEFINES_SVH

`ifndef SYNTHESIS
`define HRME_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hrme assertion failed");
`define HRME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hrme assertion failed");
`else
`define HRME_ASSERT(lbl, clk, rstn, prop)
`define HRME_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/hrme_pkg.sv
// types and constants shared by the histogram rebinning block
package hrme_pkg;

  localparam int unsigned GS_W    = 7;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CSUM_W  = 40;
  localparam int unsigned ESUM_W  = 64;
  localparam int unsigned OPND_W  = 64;
  localparam int unsigned REM_W   = 36;
  localparam int unsigned RES_W   = 40;
  localparam int unsigned STEP_W  = 6;

  localparam logic [GS_W-1:0]   GROUP_SIZE_RESET = 7'd20;
  localparam logic [GS_W-1:0]   MAX_GROUP        = 7'd64;
  localparam logic [STEP_W-1:0] MEAN_STEPS       = 6'd40;
  localparam logic [STEP_W-1:0] SQRT_STEPS       = 6'd32;
  localparam logic [STEP_W-1:0] ERR_STEPS        = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MEAN,
    ST_SQRT,
    ST_ERR,
    ST_DONE
  } state_e;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } iter_mode_e;

  typedef struct packed {
    logic              start;
    iter_mode_e        mode;
    logic [STEP_W-1:0] steps;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

### hdl/histogram_rebin_mean_error.sv
// top level: histogram rebinning with mean content and quadrature error
// a bin that does not close its group passes through accept, square and accumulate
// a closing bin of a non-empty group then runs, on one shared compare-subtract unit,
// a 40-step mean divide, a 32-step square root and a 32-step error divide;
// an empty group goes straight to the output state; a full output reg adds stall
// reset (async, active low) clears all sums, counters and sets group_size to 20
`include "histogram_rebin_mean_error_defines.svh"
module histogram_rebin_mean_error (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hrme_pkg::GS_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [hrme_pkg::DATA_W-1:0] bin_content_i,
  input  logic [hrme_pkg::DATA_W-1:0]        bin_error_i,
  input  logic                               final_bin_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [hrme_pkg::IDX_W-1:0]         group_index_o,
  output logic signed [hrme_pkg::DATA_W-1:0] mean_content_o,
  output logic [hrme_pkg::DATA_W-1:0]        merged_error_o,
  output logic                               empty_group_o,
  output logic                               last_group_o
);
  import hrme_pkg::*;

  state_e state_q, state_d;

  logic [GS_W-1:0]   group_size_q;
  logic [DATA_W-1:0] content_q;
  logic [DATA_W-1:0] error_q;
  logic              final_q;
  logic [ESUM_W-1:0] prod_q;
  logic [POS_W-1:0]  pos_q;
  logic [CSUM_W-1:0] csum_q;
  logic [ESUM_W-1:0] esum_q;
  logic [CNT_W-1:0]  counted_q;
  logic [IDX_W-1:0]  bin_num_q;
  logic [DATA_W-1:0] mean_q;
  logic [DATA_W-1:0] merr_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  group_index_q;
  logic [DATA_W-1:0] mean_out_q;
  logic [DATA_W-1:0] merr_out_q;
  logic              empty_out_q;
  logic              last_out_q;

  logic              nonzero;
  logic [GS_W-1:0]   eff_size;
  logic [GS_W-1:0]   filled;
  logic              close;
  logic              csum_neg;
  logic [CSUM_W-1:0] csum_mag;
  logic [ESUM_W:0]   esum_add;
  logic [ESUM_W-1:0] esum_sat;
  logic [RES_W-1:0]  mean_full;
  logic              out_free;
  logic              empty;

  iter_req_t         iter_req;
  iter_sts_t         iter_sts;
  logic [OPND_W-1:0] iter_operand;
  logic [RES_W-1:0]  iter_result;

  hrme_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (iter_req),
    .operand_i (iter_operand),
    .divisor_i (counted_q),
    .sts_o     (iter_sts),
    .result_o  (iter_result)
  );

  // datapath helpers
  always_comb begin
    nonzero = (content_q != '0);
    if (group_size_q == '0) begin
      eff_size = GS_W'(1);
    end else if (group_size_q > MAX_GROUP) begin
      eff_size = MAX_GROUP;
    end else begin
      eff_size = group_size_q;
    end
    filled    = {1'b0, pos_q} + GS_W'(1);
    close     = (filled >= eff_size) || final_q;
    csum_neg  = csum_q[CSUM_W-1];
    csum_mag  = csum_neg ? (~csum_q + CSUM_W'(1)) : csum_q;
    esum_add  = {1'b0, esum_q} + {1'b0, prod_q};
    esum_sat  = esum_add[ESUM_W] ? '1 : esum_add[ESUM_W-1:0];
    mean_full = csum_neg ? (~iter_result + RES_W'(1)) : iter_result;
    out_free  = !out_valid_q || out_ready_i;
    empty     = (counted_q == '0);
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    iter_req.start = 1'b0;
    iter_req.mode  = MODE_DIV;
    iter_req.steps = MEAN_STEPS;
    iter_operand   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!close) begin
          state_d = ST_IDLE;
        end else if (empty) begin
          state_d = ST_DONE;
        end else begin
          iter_req.start = 1'b1;
          iter_req.mode  = MODE_DIV;
          iter_req.steps = MEAN_STEPS;
          iter_operand   = {csum_mag, {(OPND_W-CSUM_W){1'b0}}};
          state_d        = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (iter_sts.done) begin
          iter_req.start = 1'b1;
          iter_req.mode  = MODE_SQRT;
          iter_req.steps = SQRT_STEPS;
          iter_operand   = esum_q;
          state_d        = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (iter_sts.done) begin
          iter_req.start = 1'b1;
          iter_req.mode  = MODE_DIV;
          iter_req.steps = ERR_STEPS;
          iter_operand   = {iter_result[DATA_W-1:0], {(OPND_W-DATA_W){1'b0}}};
          state_d        = ST_ERR;
        end
      end
      ST_ERR: begin
        if (iter_sts.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // group state and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RESET;
      pos_q        <= '0;
      csum_q       <= '0;
      esum_q       <= '0;
      counted_q    <= '0;
      bin_num_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      if (state_q == ST_MUL && nonzero) begin
        csum_q    <= csum_q + {{(CSUM_W-DATA_W){content_q[DATA_W-1]}}, content_q};
        counted_q <= counted_q + CNT_W'(1);
      end
      if (state_q == ST_ACC) begin
        if (nonzero) begin
          esum_q <= esum_sat;
        end
        if (!close) begin
          pos_q <= filled[POS_W-1:0];
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        pos_q       <= '0;
        csum_q      <= '0;
        esum_q      <= '0;
        counted_q   <= '0;
        bin_num_q   <= final_q ? '0 : bin_num_q + IDX_W'(1);
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      content_q <= bin_content_i;
      error_q   <= bin_error_i;
      final_q   <= final_bin_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= ESUM_W'(error_q) * ESUM_W'(error_q);
    end
    if (state_q == ST_MEAN && iter_sts.done) begin
      mean_q <= mean_full[DATA_W-1:0];
    end
    if (state_q == ST_ERR && iter_sts.done) begin
      merr_q <= iter_result[DATA_W-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      group_index_q <= bin_num_q;
      mean_out_q    <= empty ? '0 : mean_q;
      merr_out_q    <= empty ? '0 : merr_q;
      empty_out_q   <= empty;
      last_out_q    <= final_q;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign group_index_o  = group_index_q;
  assign mean_content_o = mean_out_q;
  assign merged_error_o = merr_out_q;
  assign empty_group_o  = empty_out_q;
  assign last_group_o   = last_out_q;

  `HRME_ASSERT(a_ready_unit_idle, clk_i, rst_ni, !in_ready_o || !iter_sts.busy)
  `HRME_ASSERT_NEXT(a_one_bin_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `HRME_ASSERT(a_empty_is_zero, clk_i, rst_ni, !(out_valid_o && empty_group_o) || (mean_content_o == '0 && merged_error_o == '0))

endmodule

### hdl/hrme_iter.sv
// shared restoring divide and square root unit, one digit per cycle
module hrme_iter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hrme_pkg::iter_req_t          req_i,
  input  logic [hrme_pkg::OPND_W-1:0]  operand_i,
  input  logic [hrme_pkg::CNT_W-1:0]   divisor_i,
  output hrme_pkg::iter_sts_t          sts_o,
  output logic [hrme_pkg::RES_W-1:0]   result_o
);
  import hrme_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  iter_mode_e        mode_q;
  logic [OPND_W-1:0] acc_q;
  logic [REM_W-1:0]  rem_q;
  logic [RES_W-1:0]  res_q;
  logic [CNT_W-1:0]  div_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [OPND_W-1:0] acc_nx;

  always_comb begin
    case (mode_q)
      MODE_SQRT: begin
        rem_sh = {rem_q[REM_W-3:0], acc_q[OPND_W-1 -: 2]};
        trial  = {2'b00, res_q[DATA_W-1:0], 2'b01};
        acc_nx = {acc_q[OPND_W-3:0], 2'b00};
      end
      default: begin
        rem_sh = {rem_q[REM_W-2:0], acc_q[OPND_W-1]};
        trial  = {{(REM_W-CNT_W){1'b0}}, div_q};
        acc_nx = {acc_q[OPND_W-2:0], 1'b0};
      end
    endcase
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = !diff[REM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      acc_q  <= operand_i;
      rem_q  <= '0;
      res_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_nx;
      rem_q <= ge ? diff[REM_W-1:0] : rem_sh;
      res_q <= {res_q[RES_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = res_q;

endmodule
